>>> src/mfgp_pkg.sv
// Shared types, constants and font table for the glyph plotter.
// No dependencies.
package mfgp_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int FIRST_CODE     = 32;
    localparam int LAST_CODE      = 126;
    localparam int GLYPH_COLS     = 5;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PLOT  = 2'd1,
        OP_GLYPH = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rmw_rd;
        logic rmw_wr;
        logic host_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic clr_last;
        logic step_last;
        logic draw_ok;
        logic out_full;
    } t_stat;

    // one entry per code, column 0 in the top byte
    localparam logic [39:0] GLYPH_ROM [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
        40'h3649494936, 40'h464949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201590906,
        40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    // rows of a page that fall inside the display height
    function automatic logic [7:0] row_mask(input logic [5:0] page);
        logic [7:0] m;
        for (int k = 0; k < 8; k++) begin
            m[k] = (int'(page) * 8 + k) < DISPLAY_HEIGHT;
        end
        return m;
    endfunction

endpackage

>>> src/mono_framebuffer_glyph_plotter.sv
// Top level of the page-organised framebuffer with 5x7 glyph plotter.
// Depends on mfgp_pkg, mfgp_ctrl, mfgp_datapath.
//
//  channel  signals                                               direction
//  in       i_valid/i_ready, i_op, i_x_pos, i_y_pos, i_pixel_on,  sink
//           i_char_code, i_read_address
//  out      o_valid/o_ready, o_read_byte                          source
//
// Per item: a plot reads and writes the pixel's page and the one below, a
// glyph reads and writes ten store bytes (two pages in each of five columns),
// an undrawable glyph skips the store, a read fetches one byte, a clear sweeps it.
// After reset the store is cleared by a sweep over every byte; i_ready stays low.
// A waiting read result sits in the output register; further items are
// taken meanwhile, and a following read holds until that beat has left.
module mono_framebuffer_glyph_plotter import mfgp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              i_ready,
    input  logic [1:0]        i_op,
    input  logic signed [8:0] i_x_pos,
    input  logic signed [8:0] i_y_pos,
    input  logic              i_pixel_on,
    input  logic [7:0]        i_char_code,
    input  logic [9:0]        i_read_address,
    output logic              o_valid,
    input  logic              o_ready,
    output logic [7:0]        o_read_byte
);

    t_cmd  cmd;
    t_stat stat;

    mfgp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (i_ready),
        .o_cmd   (cmd)
    );

    mfgp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_pixel_on     (i_pixel_on),
        .i_char_code    (i_char_code),
        .i_read_address (i_read_address),
        .i_out_ready    (o_ready),
        .o_stat         (stat),
        .o_out_valid    (o_valid),
        .o_read_byte    (o_read_byte)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready) |=> !i_ready)
        else $error("input taken while previous item still in progress");

    a_no_result_for_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && i_op != OP_READ) |=> !$rose(o_valid))
        else $error("result produced for a non-read item");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_ready)
        else $error("input taken before the clearing sweep");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.clr_wr, cmd.rmw_rd, cmd.rmw_wr,
                  cmd.host_rd, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

>>> src/mfgp_ctrl.sv
// Sequencer for the glyph plotter: clear sweep, read-modify-write steps, reads.
// Depends on mfgp_pkg.
module mfgp_ctrl import mfgp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WR,
        S_HOST,
        S_PUSH
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                case (i_stat.op)
                    OP_CLEAR: n_state = S_CLEAR;
                    OP_READ: begin
                        o_cmd.host_rd = 1'b1;
                        n_state       = S_PUSH;
                    end
                    default: begin
                        if (i_stat.op == OP_PLOT || i_stat.draw_ok) begin
                            o_cmd.rmw_rd = 1'b1;
                            n_state      = S_WR;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_WR: begin
                o_cmd.rmw_wr = 1'b1;
                n_state      = i_stat.step_last ? S_IDLE : S_RD;
            end
            S_HOST: n_state = S_PUSH;
            S_PUSH: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/mfgp_datapath.sv
// Frame store, item registers, address and merge logic, output register.
// Depends on mfgp_pkg.
module mfgp_datapath import mfgp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [1:0]          i_op,
    input  logic signed [8:0]   i_x_pos,
    input  logic signed [8:0]   i_y_pos,
    input  logic                i_pixel_on,
    input  logic [7:0]          i_char_code,
    input  logic [9:0]          i_read_address,
    input  logic                i_out_ready,
    output t_stat               o_stat,
    output logic                o_out_valid,
    output logic [7:0]          o_read_byte
);

    logic [7:0]        r_frame [0:STORE_BYTES-1];
    logic [7:0]        r_rdata;
    logic [1:0]        r_op;
    logic [8:0]        r_x;
    logic [8:0]        r_y;
    logic              r_lit;
    logic [7:0]        r_code;
    logic [9:0]        r_raddr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [2:0]        r_col;
    logic              r_pg;
    logic              r_out_valid;
    logic [7:0]        r_out;

    logic [6:0]        rom_idx;
    logic [7:0]        font;
    logic [7:0]        d8, m8;
    logic [15:0]       d16, m16;
    logic [7:0]        d_half, m_half;
    logic signed [6:0] page;
    logic signed [9:0] col;
    logic              visible;
    logic [ADDR_W-1:0] rmw_addr;
    logic [7:0]        merged;
    logic              code_ok;
    logic              raddr_ok;

    assign code_ok  = (r_code >= 8'(FIRST_CODE)) && (r_code <= 8'(LAST_CODE));
    assign rom_idx  = 7'(r_code - 8'(FIRST_CODE));
    assign font     = GLYPH_ROM[code_ok ? rom_idx : 7'd0][39 - 8*r_col -: 8];

    always_comb begin
        if (r_op == OP_PLOT) begin
            d8 = {7'd0, r_lit};
            m8 = 8'h01;
        end else begin
            d8 = r_lit ? font : ~font;
            m8 = 8'hFF;
        end
    end

    // cell spans two pages; shift by the row within the first page
    assign d16    = {8'd0, d8} << r_y[2:0];
    assign m16    = {8'd0, m8} << r_y[2:0];
    assign d_half = r_pg ? d16[15:8] : d16[7:0];
    assign page   = {r_y[8], r_y[8:3]} + {6'd0, r_pg};
    assign col    = {r_x[8], r_x} + {7'd0, r_col};
    assign visible = !page[6] && (7'(page) < 7'(PAGE_COUNT))
                  && !col[9] && (32'(col[8:0]) < DISPLAY_WIDTH);
    assign m_half = (r_pg ? m16[15:8] : m16[7:0]) & row_mask(page[5:0]);
    assign rmw_addr = ADDR_W'(32'(page[5:0]) * DISPLAY_WIDTH + 32'(col[8:0]));
    assign merged   = (r_rdata & ~m_half) | (d_half & m_half);
    assign raddr_ok = 32'(r_raddr) < STORE_BYTES;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_frame[r_clr_addr] <= 8'd0;
        end else if (i_cmd.rmw_wr && visible) begin
            r_frame[rmw_addr] <= merged;
        end
        if (i_cmd.rmw_rd) begin
            r_rdata <= r_frame[rmw_addr];
        end else if (i_cmd.host_rd) begin
            r_rdata <= r_frame[ADDR_W'(r_raddr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
            r_lit   <= i_pixel_on;
            r_code  <= i_char_code;
            r_raddr <= i_read_address;
        end
        if (i_cmd.out_load) begin
            r_out <= raddr_ok ? r_rdata : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_pg        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_clr_addr <= '0;
                r_col      <= '0;
                r_pg       <= 1'b0;
            end else if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else if (i_cmd.rmw_wr) begin
                r_pg <= ~r_pg;
                if (r_pg) r_col <= r_col + 3'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.op        = t_op'(r_op);
        o_stat.clr_last  = (32'(r_clr_addr) == STORE_BYTES - 1);
        o_stat.step_last = r_pg && ((r_op == OP_PLOT) ||
                                    (32'(r_col) == GLYPH_COLS - 1));
        o_stat.draw_ok   = code_ok;
        o_stat.out_full  = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_out;

endmodule

>>> bench/mono_framebuffer_glyph_plotter_test.sv
// Self-checking bench for the page-organised framebuffer glyph plotter.
// Depends on mfgp_pkg and mono_framebuffer_glyph_plotter; keeps its own pixel image.
module mono_framebuffer_glyph_plotter_test;
    import mfgp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_op              op;
        logic signed [8:0] x;
        logic signed [8:0] y;
        logic             lit;
        logic [7:0]       code;
        logic [9:0]       addr;
    } t_cmd_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              i_ready;
    logic [1:0]        i_op = '0;
    logic signed [8:0] i_x_pos = '0;
    logic signed [8:0] i_y_pos = '0;
    logic              i_pixel_on = 1'b0;
    logic [7:0]        i_char_code = '0;
    logic [9:0]        i_read_address = '0;
    logic              o_valid;
    logic              o_ready = 1'b0;
    logic [7:0]        o_read_byte;

    t_cmd_beat  pending_cmds[$];
    logic [7:0] frame_image[STORE_BYTES];
    logic [7:0] read_bytes_due[$];
    int         mismatch_count = 0;
    bit         stimulus_done = 1'b0;
    bit         in_taken = 1'b0;

    // 5x7 columns, column 0 first
    localparam logic [7:0] FONT_COLS [0:94][0:4] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14},'{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E},'{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h72,8'h49,8'h49,8'h49,8'h46},'{8'h21,8'h41,8'h49,8'h4D,8'h33},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h31},'{8'h41,8'h21,8'h11,8'h09,8'h07},
        '{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h46,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h59,8'h09,8'h06},
        '{8'h3E,8'h41,8'h5D,8'h59,8'h4E},'{8'h7C,8'h12,8'h11,8'h12,8'h7C},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36},'{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C},'{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01},'{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F},'{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01},'{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40},'{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F},'{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06},'{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01},'{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F},'{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F},'{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02},'{8'h0C,8'h52,8'h52,8'h52,8'h3E},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h20,8'h40,8'h44,8'h3D,8'h00},'{8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00},'{8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h7C,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7C},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20},'{8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C},'{8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0C,8'h50,8'h50,8'h50,8'h3C},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
        '{8'h00,8'h00,8'h7F,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
        '{8'h08,8'h08,8'h2A,8'h1C,8'h08}
    };

    mono_framebuffer_glyph_plotter u_top (.*);

    always #10 i_clk = ~i_clk;

    function automatic int gap_cycles();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic void set_pixel(input int col, input int row, input bit lit);
        int idx;
        if (col < 0 || col >= DISPLAY_WIDTH || row < 0 || row >= DISPLAY_HEIGHT) return;
        idx = col + (row / 8) * DISPLAY_WIDTH;
        frame_image[idx][row % 8] = lit;
    endfunction

    // apply one accepted command to the image, queue the byte a read returns
    function automatic void apply_cmd(input t_cmd_beat c);
        int col;
        int row;
        logic [7:0] bits;
        col = int'(c.x);
        row = int'(c.y);
        case (c.op)
            OP_CLEAR: foreach (frame_image[k]) frame_image[k] = '0;
            OP_PLOT:  set_pixel(col, row, c.lit);
            OP_GLYPH: begin
                if (c.code >= FIRST_CODE && c.code <= LAST_CODE)
                    for (int i = 0; i < 5; i++) begin
                        bits = FONT_COLS[c.code - FIRST_CODE][i];
                        for (int j = 0; j < 8; j++)
                            set_pixel(col + i, row + j, bits[j] ? c.lit : !c.lit);
                    end
            end
            OP_READ: read_bytes_due.push_back(
                (c.addr < STORE_BYTES) ? frame_image[c.addr] : 8'h00);
            default: ;
        endcase
    endfunction

    function automatic t_cmd_beat make_cmd(input t_op op, input int x, input int y,
                                           input bit lit, input int code, input int addr);
        t_cmd_beat c;
        c.op = op; c.x = x[8:0]; c.y = y[8:0]; c.lit = lit;
        c.code = code[7:0]; c.addr = addr[9:0];
        return c;
    endfunction

    // mostly on-screen positions, sometimes anywhere in the 9-bit range
    function automatic t_cmd_beat random_cmd();
        int r;
        int x;
        int y;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) begin
            x = $urandom_range(0, 511) - 256;
            y = $urandom_range(0, 511) - 256;
        end else begin
            x = $urandom_range(0, DISPLAY_WIDTH + 7) - 6;
            y = $urandom_range(0, DISPLAY_HEIGHT + 9) - 8;
        end
        if (r < 1)
            return make_cmd(OP_CLEAR, x, y, 1'($urandom), $urandom, $urandom);
        if (r < 35)
            return make_cmd(OP_PLOT, x, y, 1'($urandom), $urandom, $urandom);
        if (r < 65)
            return make_cmd(OP_GLYPH, x, y, 1'($urandom),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(32, 126),
                            $urandom);
        return make_cmd(OP_READ, x, y, 1'($urandom), $urandom,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, STORE_BYTES - 1));
    endfunction

    initial begin
        foreach (frame_image[k]) frame_image[k] = '0;
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PLOT, 0, 0, 1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PLOT, 127, 63, 1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PLOT, -256, 255, 1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PLOT, 128, 64, 1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 1023));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, STORE_BYTES - 1));
        pending_cmds.push_back(make_cmd(OP_GLYPH, 10, 3, 1, 48, 0));
        pending_cmds.push_back(make_cmd(OP_GLYPH, 125, 60, 0, 65, 0));
        pending_cmds.push_back(make_cmd(OP_GLYPH, -2, -3, 1, 126, 0));
        pending_cmds.push_back(make_cmd(OP_GLYPH, 20, 8, 1, 31, 0));
        pending_cmds.push_back(make_cmd(OP_GLYPH, 20, 8, 1, 127, 0));
        pending_cmds.push_back(make_cmd(OP_GLYPH, 30, 16, 1, 255, 0));
        pending_cmds.push_back(make_cmd(OP_GLYPH, 30, 16, 0, 32, 0));
        for (int a = 10; a < 15; a++)
            pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, a));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 128 * 7 + 127));
        pending_cmds.push_back(make_cmd(OP_PLOT, 255, -1, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 10));
        for (int n = 0; n < 1750; n++) pending_cmds.push_back(random_cmd());
        stimulus_done = 1'b1;
    end

    // driver: holds each beat until accepted
    int drive_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (drive_gap > 0 || pending_cmds.size() == 0) begin
                if (drive_gap > 0) drive_gap--;
                i_valid <= 1'b0;
            end else begin
                t_cmd_beat c;
                c = pending_cmds.pop_front();
                i_op <= c.op; i_x_pos <= c.x; i_y_pos <= c.y;
                i_pixel_on <= c.lit; i_char_code <= c.code; i_read_address <= c.addr;
                i_valid <= 1'b1;
                drive_gap = gap_cycles();
            end
        end
    end

    // read-back stall pattern
    int stall_gap = 0;
    always @(negedge i_clk) begin
        if (stall_gap > 0) begin
            stall_gap--;
            o_ready <= 1'b0;
        end else begin
            o_ready <= 1'b1;
            stall_gap = gap_cycles();
        end
    end

    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && i_ready;
        if (i_rst_n && i_valid && i_ready)
            apply_cmd('{t_op'(i_op), i_x_pos, i_y_pos, i_pixel_on, i_char_code,
                        i_read_address});
        if (i_rst_n && o_valid && o_ready) begin
            if (read_bytes_due.size() == 0) begin
                report_mismatch("unexpected read beat", o_read_byte, 8'h00);
            end else begin
                logic [7:0] want;
                want = read_bytes_due.pop_front();
                if (o_read_byte !== want) report_mismatch("read_byte", o_read_byte, want);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        wait (stimulus_done && pending_cmds.size() == 0);
        @(posedge i_clk);
        while (i_valid || read_bytes_due.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        if (read_bytes_due.size() != 0 || mismatch_count != 0)
            $display("[mono_framebuffer_glyph_plotter] ERROR");
        else
            $display("[mono_framebuffer_glyph_plotter] OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("[mono_framebuffer_glyph_plotter] ERROR");
        $finish;
    end

endmodule
